// File: src/htq_pkg.sv
// Shared types, constants and codes of the heap timer queue.
package htq_pkg;

  localparam int NUM_TIMERS = 64;
  localparam int HEAP_DEPTH = 128;

  localparam int ID_W  = 6;
  localparam int KEY_W = 64;
  localparam int PER_W = 32;
  localparam int TA_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TC_W  = TA_W + 1;
  localparam int HA_W  = $clog2(HEAP_DEPTH);
  localparam int HC_W  = HA_W + 1;
  localparam int HE_W  = KEY_W + ID_W;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_OK      = 3'd0;
  localparam logic [2:0] KIND_STATE   = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_EXPIRED = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  timer_id;
    logic [PER_W-1:0] duration_ticks;
    logic             repeat_req;
    logic [KEY_W-1:0] now_tick;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] expired_id;
    logic            last;
  } result_t;

  // Key above id: a plain unsigned compare orders by expiry, then id
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  tid;
  } heap_entry_t;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_PUSH,
    HOP_POP,
    HOP_PEEK
  } heap_op_e;

  typedef struct packed {
    heap_op_e    op;
    heap_entry_t entry;
  } heap_req_t;

  typedef struct packed {
    logic            done;
    logic [HC_W-1:0] count;
    heap_entry_t     top;
  } heap_stat_t;

  typedef struct packed {
    logic             rd_en;
    logic [TA_W-1:0]  rd_addr;
    logic             wr_exp;
    logic             wr_per;
    logic [TA_W-1:0]  wr_addr;
    logic [KEY_W-1:0] exp;
    logic [PER_W-1:0] per;
    logic [TA_W-1:0]  flag_addr;
    logic             set_run;
    logic             clr_run;
    logic             wr_rep;
    logic             rep;
  } tmr_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] exp;
    logic [PER_W-1:0] per;
    logic             running;
    logic             repeating;
  } tmr_stat_t;

  typedef enum logic [3:0] {
    HS_IDLE,
    HS_PU_RD,
    HS_PU_CMP,
    HS_PO_LAST,
    HS_PO_RDL,
    HS_PO_RDR,
    HS_PO_CMP,
    HS_PK_CAP
  } heap_state_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_START_WAIT,
    T_TK_TOP,
    T_TK_PEEK,
    T_TK_CHK,
    T_TK_POP,
    T_RA_RD,
    T_RA_TM,
    T_RA_PUSH,
    T_RA_WAIT,
    T_TK_END
  } top_state_e;

endpackage

// File: src/heap_timer_queue_unit.sv
// Top level of the heap timer queue: command sequencer and result register.
//
// channel   direction  handshake             payload
// command   in         start & !busy         command (cmd_t)
// result    out        strobe, one cycle     result (result_t)
//
// Stop, and a refused start, are answered from the idle state; an accepted start
// adds one heap push. A tick takes per popped entry a peek and a pop, then per
// rearmed timer a read of the pending list and the timer record plus a push.
// The heap memory serves one read per cycle.
// Reset clears all control state and the flag bits at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module heap_timer_queue_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  htq_pkg::cmd_t    command,
  output logic             strobe,
  output htq_pkg::result_t result
);
  import htq_pkg::*;

  top_state_e state, state_next;
  cmd_t item, item_next;
  logic [TC_W-1:0] npend, npend_next;
  logic [TC_W-1:0] ridx, ridx_next;
  logic hold_valid, hold_valid_next;
  logic [ID_W-1:0] hold_id, hold_id_next;
  logic strobe_next;
  result_t result_q, result_next;

  logic [ID_W-1:0] pend_mem [NUM_TIMERS];
  logic [ID_W-1:0] pend_rd;
  logic pend_we;

  heap_req_t  hreq;
  heap_stat_t hstat;
  tmr_req_t   treq;
  tmr_stat_t  tstat;

  logic [PER_W-1:0] start_per;
  logic [KEY_W-1:0] start_exp;
  logic [KEY_W-1:0] rearm_exp;
  logic             id_ok;
  logic             top_ok;
  logic             live;

  // Saturating add of a period to the current tick
  function automatic logic [KEY_W-1:0] sat_add(input logic [KEY_W-1:0] now,
                                               input logic [PER_W-1:0] per);
    logic [KEY_W:0] sum;
    sum = {1'b0, now} + (KEY_W+1)'(per);
    return sum[KEY_W] ? '1 : sum[KEY_W-1:0];
  endfunction

  htq_heap u_heap (
    .clk  (clk),
    .rst  (rst),
    .req  (hreq),
    .stat (hstat)
  );

  htq_timers u_timers (
    .clk  (clk),
    .rst  (rst),
    .req  (treq),
    .stat (tstat)
  );

  assign start_per = (command.duration_ticks == '0) ? PER_W'(1) : command.duration_ticks;
  assign start_exp = sat_add(command.now_tick, start_per);
  assign rearm_exp = sat_add(item.now_tick, tstat.per);
  assign id_ok     = int'(command.timer_id) < NUM_TIMERS;
  assign top_ok    = int'(hstat.top.tid) < NUM_TIMERS;
  assign live      = top_ok && tstat.running && (tstat.exp == hstat.top.key);

  // Pending rearm list
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[npend[TA_W-1:0]] <= hstat.top.tid;
    end
    if (state == T_RA_RD) begin
      pend_rd <= pend_mem[ridx[TA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      strobe     <= 1'b0;
      hold_valid <= 1'b0;
      npend      <= '0;
      ridx       <= '0;
    end else begin
      state      <= state_next;
      strobe     <= strobe_next;
      hold_valid <= hold_valid_next;
      npend      <= npend_next;
      ridx       <= ridx_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    hold_id  <= hold_id_next;
    result_q <= result_next;
  end

  // Sequence commands, heap walks and rearming
  always_comb begin
    state_next      = state;
    item_next       = item;
    npend_next      = npend;
    ridx_next       = ridx;
    hold_valid_next = hold_valid;
    hold_id_next    = hold_id;
    strobe_next     = 1'b0;
    result_next     = result_q;
    pend_we         = 1'b0;
    hreq            = '{op: HOP_NONE, entry: '0};
    treq            = '0;
    treq.flag_addr  = command.timer_id[TA_W-1:0];
    unique case (state)
      T_IDLE: begin
        if (start) begin
          item_next = command;
          unique case (command.cmd)
            CMD_START: begin
              if (!id_ok || tstat.running) begin
                strobe_next = 1'b1;
                result_next = '{kind: KIND_STATE, expired_id: command.timer_id, last: 1'b1};
              end else if (hstat.count >= HC_W'(HEAP_DEPTH)) begin
                strobe_next = 1'b1;
                result_next = '{kind: KIND_FULL, expired_id: command.timer_id, last: 1'b1};
              end else begin
                treq.wr_exp  = 1'b1;
                treq.wr_per  = 1'b1;
                treq.wr_addr = command.timer_id[TA_W-1:0];
                treq.exp     = start_exp;
                treq.per     = start_per;
                treq.set_run = 1'b1;
                treq.wr_rep  = 1'b1;
                treq.rep     = command.repeat_req;
                hreq.op      = HOP_PUSH;
                hreq.entry   = '{key: start_exp, tid: command.timer_id};
                state_next   = T_START_WAIT;
              end
            end
            CMD_STOP: begin
              strobe_next = 1'b1;
              if (!id_ok || !tstat.running) begin
                result_next = '{kind: KIND_STATE, expired_id: command.timer_id, last: 1'b1};
              end else begin
                treq.clr_run = 1'b1;
                result_next  = '{kind: KIND_OK, expired_id: command.timer_id, last: 1'b1};
              end
            end
            CMD_TICK: begin
              hold_valid_next = 1'b0;
              npend_next      = '0;
              state_next      = T_TK_TOP;
            end
            default: ;
          endcase
        end
      end
      T_START_WAIT: begin
        if (hstat.done) begin
          strobe_next = 1'b1;
          result_next = '{kind: KIND_OK, expired_id: item.timer_id, last: 1'b1};
          state_next  = T_IDLE;
        end
      end
      T_TK_TOP: begin
        if (hstat.count == '0) begin
          ridx_next  = '0;
          state_next = (npend == '0) ? T_TK_END : T_RA_RD;
        end else begin
          hreq.op    = HOP_PEEK;
          state_next = T_TK_PEEK;
        end
      end
      T_TK_PEEK: begin
        if (hstat.done) begin
          state_next = T_TK_CHK;
        end
      end
      T_TK_CHK: begin
        if (hstat.top.key > item.now_tick) begin
          ridx_next  = '0;
          state_next = (npend == '0) ? T_TK_END : T_RA_RD;
        end else begin
          treq.rd_en   = 1'b1;
          treq.rd_addr = hstat.top.tid[TA_W-1:0];
          hreq.op      = HOP_POP;
          state_next   = T_TK_POP;
        end
      end
      T_TK_POP: begin
        treq.flag_addr = hstat.top.tid[TA_W-1:0];
        if (hstat.done) begin
          if (live) begin
            treq.clr_run = 1'b1;
            if (hold_valid) begin
              strobe_next = 1'b1;
              result_next = '{kind: KIND_EXPIRED, expired_id: hold_id, last: 1'b0};
            end
            hold_valid_next = 1'b1;
            hold_id_next    = hstat.top.tid;
            if (tstat.repeating) begin
              pend_we    = 1'b1;
              npend_next = npend + TC_W'(1);
            end
          end
          state_next = T_TK_TOP;
        end
      end
      T_RA_RD: begin
        state_next = T_RA_TM;
      end
      T_RA_TM: begin
        treq.rd_en   = 1'b1;
        treq.rd_addr = pend_rd[TA_W-1:0];
        state_next   = T_RA_PUSH;
      end
      T_RA_PUSH: begin
        treq.flag_addr = pend_rd[TA_W-1:0];
        treq.wr_addr   = pend_rd[TA_W-1:0];
        treq.wr_exp    = 1'b1;
        treq.exp       = rearm_exp;
        treq.set_run   = 1'b1;
        hreq.op        = HOP_PUSH;
        hreq.entry     = '{key: rearm_exp, tid: pend_rd};
        state_next     = T_RA_WAIT;
      end
      T_RA_WAIT: begin
        if (hstat.done) begin
          ridx_next  = ridx + TC_W'(1);
          state_next = (ridx + TC_W'(1) == npend) ? T_TK_END : T_RA_RD;
        end
      end
      T_TK_END: begin
        strobe_next = 1'b1;
        if (hold_valid) begin
          result_next = '{kind: KIND_EXPIRED, expired_id: hold_id, last: 1'b1};
        end else begin
          result_next = '{kind: KIND_NONE, expired_id: item.timer_id, last: 1'b1};
        end
        state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  assign busy   = (state != T_IDLE);
  assign result = result_q;

endmodule

// File: src/htq_timers.sv
// Timer record store: expiry and period memories, running and repeat flags.
module htq_timers (
  input  logic               clk,
  input  logic               rst,
  input  htq_pkg::tmr_req_t  req,
  output htq_pkg::tmr_stat_t stat
);
  import htq_pkg::*;

  logic [KEY_W-1:0]      exp_mem [NUM_TIMERS];
  logic [PER_W-1:0]      per_mem [NUM_TIMERS];
  logic [KEY_W-1:0]      exp_rd;
  logic [PER_W-1:0]      per_rd;
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] repeating;

  // Write and read the record memories
  always_ff @(posedge clk) begin
    if (req.wr_exp) begin
      exp_mem[req.wr_addr] <= req.exp;
    end
    if (req.wr_per) begin
      per_mem[req.wr_addr] <= req.per;
    end
    if (req.rd_en) begin
      exp_rd <= exp_mem[req.rd_addr];
      per_rd <= per_mem[req.rd_addr];
    end
  end

  // Update the flag bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      repeating <= '0;
    end else begin
      if (req.set_run) begin
        running[req.flag_addr] <= 1'b1;
      end else if (req.clr_run) begin
        running[req.flag_addr] <= 1'b0;
      end
      if (req.wr_rep) begin
        repeating[req.flag_addr] <= req.rep;
      end
    end
  end

  assign stat.exp       = exp_rd;
  assign stat.per       = per_rd;
  assign stat.running   = running[req.flag_addr];
  assign stat.repeating = repeating[req.flag_addr];

endmodule

// File: src/htq_heap.sv
// Min-heap engine: heap memory with sequential push, pop and peek.
module htq_heap (
  input  logic                clk,
  input  logic                rst,
  input  htq_pkg::heap_req_t  req,
  output htq_pkg::heap_stat_t stat
);
  import htq_pkg::*;

  localparam int IX_W = HC_W + 1;

  heap_entry_t mem [HEAP_DEPTH];
  heap_entry_t rd_data;
  heap_state_e state, state_next;
  logic [HC_W-1:0] count, count_next;
  logic [HA_W-1:0] idx, idx_next;
  heap_entry_t moving, moving_next;
  heap_entry_t child_l, child_l_next;
  heap_entry_t top, top_next;
  logic done, done_next;

  logic re, we;
  logic [HA_W-1:0] ra, wa;
  heap_entry_t wd;
  logic [IX_W-1:0] l_ix, r_ix;
  logic [HA_W-1:0] p_ix;
  heap_entry_t best;
  logic [HA_W-1:0] best_ix;
  logic moved;

  // Child and parent positions of the hole
  assign l_ix = IX_W'({idx, 1'b1});
  assign r_ix = l_ix + IX_W'(1);
  assign p_ix = (idx - HA_W'(1)) >> 1;

  // Heap memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    moving  <= moving_next;
    child_l <= child_l_next;
    top     <= top_next;
  end

  // Sequence push (sift up) and pop (sift down) around a hole, and peek
  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    moving_next  = moving;
    child_l_next = child_l;
    top_next     = top;
    done_next    = 1'b0;
    re           = 1'b0;
    ra           = '0;
    we           = 1'b0;
    wa           = idx;
    wd           = moving;
    best         = moving;
    best_ix      = idx;
    moved        = 1'b0;
    unique case (state)
      HS_IDLE: begin
        unique case (req.op)
          HOP_PUSH: begin
            if (count == HC_W'(HEAP_DEPTH)) begin
              done_next = 1'b1;
            end else begin
              moving_next = req.entry;
              idx_next    = count[HA_W-1:0];
              count_next  = count + HC_W'(1);
              state_next  = HS_PU_RD;
            end
          end
          HOP_POP: begin
            if (count == '0) begin
              done_next = 1'b1;
            end else begin
              count_next = count - HC_W'(1);
              re         = 1'b1;
              ra         = HA_W'(count - HC_W'(1));
              state_next = HS_PO_LAST;
            end
          end
          HOP_PEEK: begin
            re         = 1'b1;
            ra         = '0;
            state_next = HS_PK_CAP;
          end
          default: ;
        endcase
      end
      HS_PU_RD: begin
        if (idx == '0) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = HS_IDLE;
        end else begin
          re         = 1'b1;
          ra         = p_ix;
          state_next = HS_PU_CMP;
        end
      end
      HS_PU_CMP: begin
        we = 1'b1;
        if (HE_W'(moving) < HE_W'(rd_data)) begin
          wd         = rd_data;
          idx_next   = p_ix;
          state_next = HS_PU_RD;
        end else begin
          done_next  = 1'b1;
          state_next = HS_IDLE;
        end
      end
      HS_PO_LAST: begin
        moving_next = rd_data;
        idx_next    = '0;
        if (count == '0) begin
          done_next  = 1'b1;
          state_next = HS_IDLE;
        end else begin
          state_next = HS_PO_RDL;
        end
      end
      HS_PO_RDL: begin
        if (l_ix >= IX_W'(count)) begin
          we         = 1'b1;
          done_next  = 1'b1;
          state_next = HS_IDLE;
        end else begin
          re         = 1'b1;
          ra         = l_ix[HA_W-1:0];
          state_next = HS_PO_RDR;
        end
      end
      HS_PO_RDR: begin
        child_l_next = rd_data;
        if (r_ix < IX_W'(count)) begin
          re = 1'b1;
          ra = r_ix[HA_W-1:0];
        end
        state_next = HS_PO_CMP;
      end
      HS_PO_CMP: begin
        if (HE_W'(child_l) < HE_W'(moving)) begin
          best    = child_l;
          best_ix = l_ix[HA_W-1:0];
          moved   = 1'b1;
        end
        if (r_ix < IX_W'(count) && HE_W'(rd_data) < HE_W'(best)) begin
          best    = rd_data;
          best_ix = r_ix[HA_W-1:0];
          moved   = 1'b1;
        end
        we = 1'b1;
        wd = best;
        if (moved) begin
          idx_next   = best_ix;
          state_next = HS_PO_RDL;
        end else begin
          done_next  = 1'b1;
          state_next = HS_IDLE;
        end
      end
      HS_PK_CAP: begin
        top_next   = rd_data;
        done_next  = 1'b1;
        state_next = HS_IDLE;
      end
      default: state_next = HS_IDLE;
    endcase
  end

  assign stat.done  = done;
  assign stat.count = count;
  assign stat.top   = top;

endmodule

// File: tb/tb_heap_timer_queue_unit.sv
// Self-checking testbench for the heap timer queue: directed and random command streams.
`timescale 1ns / 100ps

module tb_heap_timer_queue_unit;
  import htq_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 400;

  // Command code with no meaning to the block
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    command;
  logic    strobe;
  result_t result;

  heap_timer_queue_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .strobe  (strobe),
    .result  (result)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow state of the timer bank and heap
  logic [KEY_W-1:0] shadow_expiry [NUM_TIMERS];
  logic [PER_W-1:0] shadow_period [NUM_TIMERS];
  logic             shadow_running [NUM_TIMERS];
  logic             shadow_repeat [NUM_TIMERS];
  logic [HE_W-1:0]  shadow_heap [HEAP_DEPTH];
  int               shadow_count;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];

  int n_errors;
  int n_sent;
  int n_results;
  int n_expired;
  int n_full;
  int idle_cycles;
  int burst_left;
  int gap_left;

  function automatic logic [KEY_W-1:0] sat_expiry(logic [KEY_W-1:0] now,
                                                   logic [PER_W-1:0] per);
    logic [KEY_W:0] sum;
    sum = {1'b0, now} + {33'd0, per};
    return sum[KEY_W] ? {KEY_W{1'b1}} : sum[KEY_W-1:0];
  endfunction

  task automatic shadow_insert(logic [HE_W-1:0] ent);
    int i;
    int p;
    logic [HE_W-1:0] tmp;
    if (shadow_count >= HEAP_DEPTH) return;
    i = shadow_count;
    shadow_count++;
    shadow_heap[i] = ent;
    // sift up; key above id so a plain compare orders both
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(shadow_heap[i] < shadow_heap[p])) break;
      tmp = shadow_heap[i];
      shadow_heap[i] = shadow_heap[p];
      shadow_heap[p] = tmp;
      i = p;
    end
  endtask

  task automatic shadow_remove_top();
    int i;
    int l;
    int r;
    int m;
    logic [HE_W-1:0] tmp;
    if (shadow_count == 0) return;
    shadow_count--;
    shadow_heap[0] = shadow_heap[shadow_count];
    i = 0;
    // sift down
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < shadow_count && shadow_heap[l] < shadow_heap[m]) m = l;
      if (r < shadow_count && shadow_heap[r] < shadow_heap[m]) m = r;
      if (m == i) break;
      tmp = shadow_heap[i];
      shadow_heap[i] = shadow_heap[m];
      shadow_heap[m] = tmp;
      i = m;
    end
  endtask

  task automatic push_result(logic [2:0] kind, logic [ID_W-1:0] id, logic last);
    result_t r;
    r.kind = kind;
    r.expired_id = id;
    r.last = last;
    expected_results.push_back(r);
  endtask

  // Work out the results of one accepted command
  task automatic predict_results(cmd_t c);
    int t;
    int n;
    logic [KEY_W-1:0] k;
    int rearm[$];
    result_t r;
    t = int'(c.timer_id);
    case (c.cmd)
      CMD_START: begin
        if (shadow_running[t]) begin
          push_result(KIND_STATE, c.timer_id, 1'b1);
        end else if (shadow_count >= HEAP_DEPTH) begin
          push_result(KIND_FULL, c.timer_id, 1'b1);
          n_full++;
        end else begin
          shadow_period[t] = (c.duration_ticks == 0) ? 32'd1 : c.duration_ticks;
          shadow_repeat[t] = c.repeat_req;
          shadow_expiry[t] = sat_expiry(c.now_tick, shadow_period[t]);
          shadow_running[t] = 1'b1;
          shadow_insert({shadow_expiry[t], c.timer_id});
          push_result(KIND_OK, c.timer_id, 1'b1);
        end
      end
      CMD_STOP: begin
        if (!shadow_running[t]) begin
          push_result(KIND_STATE, c.timer_id, 1'b1);
        end else begin
          shadow_running[t] = 1'b0;
          push_result(KIND_OK, c.timer_id, 1'b1);
        end
      end
      CMD_TICK: begin
        n = 0;
        // pop everything due, report live entries, rearm afterwards
        while (shadow_count > 0 && shadow_heap[0][HE_W-1:ID_W] <= c.now_tick) begin
          t = int'(shadow_heap[0][ID_W-1:0]);
          k = shadow_heap[0][HE_W-1:ID_W];
          shadow_remove_top();
          if (shadow_running[t] && shadow_expiry[t] == k) begin
            shadow_running[t] = 1'b0;
            if (n < 64) begin
              push_result(KIND_EXPIRED, t[ID_W-1:0], 1'b0);
              n++;
              n_expired++;
            end
            if (shadow_repeat[t] && rearm.size() < NUM_TIMERS) rearm.push_back(t);
          end
        end
        foreach (rearm[j]) begin
          shadow_expiry[rearm[j]] = sat_expiry(c.now_tick, shadow_period[rearm[j]]);
          shadow_running[rearm[j]] = 1'b1;
          shadow_insert({shadow_expiry[rearm[j]], rearm[j][ID_W-1:0]});
        end
        if (n == 0) begin
          push_result(KIND_NONE, c.timer_id, 1'b1);
        end else begin
          r = expected_results.pop_back();
          r.last = 1'b1;
          expected_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      command <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_results(command);
        n_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          command <= pending_cmds.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d last=%0d",
               result.kind, result.expired_id, result.last);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, result.kind);
          n_errors++;
        end
        if (result.expired_id !== want.expired_id) begin
          $error("expired_id: expected %0d, actual %0d", want.expired_id,
                 result.expired_id);
          n_errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, result.last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired: %0d results still outstanding",
                 expected_results.size());
        $display("tb_heap_timer_queue_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, int id, logic [31:0] dur, logic rep,
                         logic [63:0] now);
    cmd_t c;
    c.cmd = op;
    c.timer_id = id[ID_W-1:0];
    c.duration_ticks = dur;
    c.repeat_req = rep;
    c.now_tick = now;
    pending_cmds.push_back(c);
  endtask

  initial begin
    logic [63:0] now_base;
    int sel;
    int id;
    logic [31:0] dur;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      shadow_expiry[i] = '0;
      shadow_period[i] = '0;
      shadow_running[i] = 1'b0;
      shadow_repeat[i] = 1'b0;
    end
    shadow_count = 0;
    n_errors = 0;
    n_sent = 0;
    n_results = 0;
    n_expired = 0;
    n_full = 0;
    rst = 1'b1;
    start = 1'b0;
    command = '0;

    // Directed: zero period, double start, stop of idle timer, saturation,
    // equal expiries, stale entries, unknown command, repeat rearm
    add_cmd(CMD_START, 0, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_START, 0, 32'd7, 1'b0, 64'd0);
    add_cmd(CMD_STOP, 1, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_START, 63, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFB);
    add_cmd(CMD_START, 2, 32'd5, 1'b0, 64'd0);
    add_cmd(CMD_START, 1, 32'd5, 1'b1, 64'd0);
    add_cmd(CMD_START, 3, 32'd5, 1'b0, 64'd0);
    add_cmd(CMD_STOP, 3, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_TICK, 42, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_TICK, 21, 32'd0, 1'b0, 64'd10);
    add_cmd(CMD_TICK, 63, 32'hFFFF_FFFF, 1'b1, 64'd10);
    add_cmd(CMD_BAD, 63, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_TICK, 0, 32'd0, 1'b0, 64'd15);
    add_cmd(CMD_STOP, 1, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_START, 5, 32'd3, 1'b1, 64'd100);
    add_cmd(CMD_TICK, 5, 32'd0, 1'b0, 64'd103);
    add_cmd(CMD_TICK, 5, 32'd0, 1'b0, 64'd200);
    add_cmd(CMD_STOP, 5, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_TICK, 0, 32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cmd(CMD_STOP, 63, 32'd0, 1'b0, 64'd0);

    // Fill the heap: start every timer, stop all, start all again, then
    // restart a stopped timer so the start is refused; a late tick drains it
    for (int i = 0; i < NUM_TIMERS; i++) begin
      add_cmd(CMD_START, i, 32'd1000, 1'b0, 64'd0);
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      add_cmd(CMD_STOP, i, 32'd0, 1'b0, 64'd0);
    end
    for (int i = 0; i < NUM_TIMERS; i++) begin
      add_cmd(CMD_START, i, 32'd1000, 1'b0, 64'd0);
    end
    add_cmd(CMD_STOP, 0, 32'd0, 1'b0, 64'd0);
    add_cmd(CMD_START, 0, 32'd1000, 1'b0, 64'd0);
    add_cmd(CMD_TICK, 9, 32'd0, 1'b0, 64'd1 << 40);

    // Random: mostly well-formed traffic on a moving clock, some noise
    now_base = 64'd1000;
    for (int i = 0; i < 35; i++) begin
      sel = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
      dur = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 20);
      if (sel < 42) begin
        add_cmd(CMD_START, id, dur, 1'($urandom_range(0, 1)), now_base);
      end else if (sel < 57) begin
        add_cmd(CMD_STOP, id, $urandom(), 1'($urandom_range(0, 1)),
                {$urandom(), $urandom()});
      end else if (sel < 92) begin
        now_base = now_base + 64'($urandom_range(0, 15));
        add_cmd(CMD_TICK, id, $urandom(), 1'($urandom_range(0, 1)), now_base);
      end else if (sel < 96) begin
        add_cmd(CMD_TICK, id, dur, 1'($urandom_range(0, 1)), {$urandom(), $urandom()});
      end else begin
        add_cmd(CMD_BAD, id, $urandom(), 1'($urandom_range(0, 1)),
                {$urandom(), $urandom()});
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for all commands and results, then let trailing pushes settle
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked, %0d expiries, %0d heap-full refusals",
             n_sent, n_results, n_expired, n_full);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb_heap_timer_queue_unit: PASS");
    end else begin
      $display("tb_heap_timer_queue_unit: FAIL");
    end
    $finish;
  end

endmodule
